// ===== hdl/rwsn_pkg.sv =====
`default_nettype none

package rwsn_pkg;

  localparam int WINDOW_DEPTH_DEF = 40;
  localparam int SAMPLE_W         = 8;
  localparam int OUT_COUNT_W      = 6;
  localparam int S_TDATA_W        = 8;
  localparam int M_TDATA_W        = 48;
  localparam int M_TUSER_W        = 3;

  localparam logic signed [SAMPLE_W-1:0] MAX_START = -8'sd120;
  localparam logic signed [SAMPLE_W-1:0] MIN_START = 8'sd0;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    DIV_ALL   = 2'd0,
    DIV_SIG   = 2'd1,
    DIV_NOISE = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     accept;
    logic     scan_issue;
    logic     div_start;
    div_sel_t div_sel;
    logic     div_store;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic scan_last;
    logic div_busy;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/rwsn_ram.sv =====
`default_nettype none

module rwsn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 40
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/rwsn_div.sv =====
`default_nettype none

module rwsn_div
  import rwsn_pkg::*;
#(
  parameter int SUM_W = 17,
  parameter int CNT_W = 6
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [SUM_W-1:0] dividend,
  input  wire logic        [CNT_W-1:0] divisor,
  output logic                         busy,
  output logic                         done,
  output logic signed [SAMPLE_W-1:0]   quotient
);

  localparam int STEP_W = $clog2(SAMPLE_W);

  logic [SUM_W-1:0]    rem;
  logic [SUM_W-1:0]    dsh;
  logic [SAMPLE_W-1:0] q;
  logic                neg;
  logic [STEP_W-1:0]   step;
  logic                ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Quotient is known to stay below 2**SAMPLE_W, so SAMPLE_W restoring steps suffice.
  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[SUM_W-1];
      rem  <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      dsh  <= SUM_W'(divisor) << (SAMPLE_W - 1);
      q    <= '0;
      step <= STEP_W'(SAMPLE_W - 1);
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      q    <= {q[SAMPLE_W-2:0], ge};
      dsh  <= dsh >> 1;
      step <= step - 1'b1;
    end
  end

  assign quotient = neg ? $signed(-q) : $signed(q);

  ap_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("divider done without a finished run");
  ap_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider restarted while busy");
  ap_busy_len: assert property (@(posedge clk) disable iff (rst)
    start |=> busy)
    else $error("divider did not start");

endmodule

`default_nettype wire

// ===== hdl/rwsn_datapath.sv =====
`default_nettype none

module rwsn_datapath
  import rwsn_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  input  wire logic                 s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata,
  output logic [M_TUSER_W-1:0]      m_tuser
);

  localparam int AW    = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = SAMPLE_W + CNT_W + 1;

  logic        [AW-1:0]       wp;
  logic        [CNT_W-1:0]    fill;
  logic signed [SAMPLE_W-1:0] tmin;
  logic signed [SAMPLE_W-1:0] tmax;
  logic signed [SAMPLE_W-1:0] smp;
  logic                       wr_en;

  logic        [AW-1:0]       idx;
  logic                       rd_pending;
  logic        [SAMPLE_W-1:0] rd_data;
  logic signed [SAMPLE_W:0]   mm_sum;
  logic signed [SAMPLE_W:0]   mid;
  logic signed [SAMPLE_W:0]   rd_ext;
  logic signed [SUM_W-1:0]    sum_all;
  logic signed [SUM_W-1:0]    sum_sig;
  logic        [CNT_W-1:0]    cnt_sig;

  logic signed [SUM_W-1:0]    div_num;
  logic        [CNT_W-1:0]    div_den;
  logic signed [SAMPLE_W-1:0] div_q;
  logic                       div_busy;
  logic                       div_done;

  logic signed [SAMPLE_W-1:0] wmean;
  logic signed [SAMPLE_W-1:0] smean;
  logic signed [SAMPLE_W-1:0] nmean;
  logic                       wvalid;
  logic                       svalid;
  logic                       nvalid;

  assign smp   = $signed(s_tdata[SAMPLE_W-1:0]);
  assign wr_en = cmd.accept && (s_tuser == OP_ADD);

  // Window update on accepted transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
      tmin <= MIN_START;
      tmax <= MAX_START;
    end else if (cmd.accept) begin
      if (s_tuser == OP_CLEAR) begin
        wp   <= '0;
        fill <= '0;
        tmin <= MIN_START;
        tmax <= MAX_START;
      end else begin
        if (smp > tmax) begin
          tmax <= smp;
        end
        if (smp < tmin) begin
          tmin <= smp;
        end
        wp <= (wp == AW'(WINDOW_DEPTH - 1)) ? '0 : wp + 1'b1;
        if (fill < CNT_W'(WINDOW_DEPTH)) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  rwsn_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WINDOW_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wp),
    .wdata(s_tdata[SAMPLE_W-1:0]),
    .raddr(idx),
    .rdata(rd_data)
  );

  // Midpoint truncated toward zero.
  assign mm_sum = (SAMPLE_W+1)'(tmin) + (SAMPLE_W+1)'(tmax);
  assign mid    = $signed(mm_sum + (SAMPLE_W+1)'(mm_sum[SAMPLE_W])) >>> 1;
  assign rd_ext = (SAMPLE_W+1)'($signed(rd_data));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= cmd.scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx     <= '0;
      sum_all <= '0;
      sum_sig <= '0;
      cnt_sig <= '0;
    end else begin
      if (cmd.scan_issue) begin
        idx <= idx + 1'b1;
      end
      if (rd_pending) begin
        sum_all <= sum_all + SUM_W'(rd_ext);
        if (rd_ext > mid) begin
          sum_sig <= sum_sig + SUM_W'(rd_ext);
          cnt_sig <= cnt_sig + 1'b1;
        end
      end
    end
  end

  always_comb begin
    unique case (cmd.div_sel)
      DIV_SIG: begin
        div_num = sum_sig;
        div_den = cnt_sig;
      end
      DIV_NOISE: begin
        div_num = sum_all - sum_sig;
        div_den = fill - cnt_sig;
      end
      default: begin
        div_num = sum_all;
        div_den = fill;
      end
    endcase
  end

  rwsn_div #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(div_num),
    .divisor (div_den),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(div_q)
  );

  // Empty set gives a zero mean with its flag cleared.
  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      unique case (cmd.div_sel)
        DIV_SIG: begin
          smean  <= (div_den == '0) ? '0 : div_q;
          svalid <= (div_den != '0);
        end
        DIV_NOISE: begin
          nmean  <= (div_den == '0) ? '0 : div_q;
          nvalid <= (div_den != '0);
        end
        default: begin
          wmean  <= (div_den == '0) ? '0 : div_q;
          wvalid <= (div_den != '0);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {2'b00, nmean, smean, wmean, tmax, tmin, OUT_COUNT_W'(fill)};
      m_tuser <= {nvalid, svalid, wvalid};
    end
  end

  assign sts.fill_zero = (fill == '0);
  assign sts.scan_last = (CNT_W'(idx) == fill - 1'b1);
  assign sts.div_busy  = div_busy;
  assign sts.div_done  = div_done;
  assign sts.out_free  = !m_tvalid || m_tready;

  ap_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(WINDOW_DEPTH))
    else $error("fill count above window depth");
  ap_sig_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> cnt_sig <= fill)
    else $error("signal count above fill count");
  ap_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_issue |-> CNT_W'(idx) < fill)
    else $error("scan read past filled entries");

endmodule

`default_nettype wire

// ===== hdl/rwsn_ctrl.sv =====
`default_nettype none

module rwsn_ctrl
  import rwsn_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DIV_GO,
    S_DIV_WAIT,
    S_FINISH
  } state_t;

  state_t   state;
  state_t   state_next;
  div_sel_t sel;
  div_sel_t sel_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.div_sel = sel;
    state_next = state;
    sel_next   = sel;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          sel_next   = DIV_ALL;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.fill_zero) begin
          state_next = S_DIV_GO;
        end else begin
          cmd.scan_issue = 1'b1;
          if (sts.scan_last) begin
            state_next = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        state_next = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          unique case (sel)
            DIV_ALL: begin
              sel_next   = DIV_SIG;
              state_next = S_DIV_GO;
            end
            DIV_SIG: begin
              sel_next   = DIV_NOISE;
              state_next = S_DIV_GO;
            end
            default: begin
              state_next = S_FINISH;
            end
          endcase
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= DIV_ALL;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  ap_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !sts.div_busy)
    else $error("division started while divider busy");
  ap_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending transfer");
  ap_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_issue |-> !sts.fill_zero)
    else $error("scan issued on empty window");
  ap_store_after_noise: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> $past(sel) == DIV_NOISE)
    else $error("result loaded before all means were stored");

endmodule

`default_nettype wire

// ===== hdl/rssi_window_signal_noise_stats_unit.sv =====
// One item is worked at a time; the window scan reads one stored sample per cycle
// from the ring RAM, then one shared 8-step divider forms the three means.
// Reset (rst, synchronous): empty window, min 0, max -120, no result pending.
`default_nettype none

module rssi_window_signal_noise_stats_unit
  import rwsn_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,  // [7:0] sample
  input  wire logic                 s_tuser,  // [0] opcode
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // [5:0] sample_count, [13:6] running_min, [21:14] running_max,
  // [29:22] window_mean, [37:30] signal_mean, [45:38] noise_mean, [47:46] zero
  output logic [M_TDATA_W-1:0]      m_tdata,
  // [0] mean_valid, [1] signal_valid, [2] noise_valid
  output logic [M_TUSER_W-1:0]      m_tuser
);

  cmd_t cmd;
  sts_t sts;

  rwsn_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  rwsn_datapath #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule

`default_nettype wire

// ===== dv/tb_rssi_window_signal_noise_stats_unit.sv =====
module tb_rssi_window_signal_noise_stats_unit;
  import rwsn_pkg::*;

  localparam int DEPTH = WINDOW_DEPTH_DEF;

  typedef struct {
    logic [OUT_COUNT_W-1:0] count;
    logic signed [7:0] min_v;
    logic signed [7:0] max_v;
    logic signed [7:0] all_mean;
    logic all_ok;
    logic signed [7:0] sig_mean;
    logic sig_ok;
    logic signed [7:0] noise_mean;
    logic noise_ok;
  } stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;  // [7:0] sample
  logic s_tuser = OP_ADD;              // [0] opcode
  logic m_tvalid;
  logic m_tready = 1'b0;
  // [5:0] sample_count, [13:6] running_min, [21:14] running_max,
  // [29:22] window_mean, [37:30] signal_mean, [45:38] noise_mean
  logic [M_TDATA_W-1:0] m_tdata;
  // [0] mean_valid, [1] signal_valid, [2] noise_valid
  logic [M_TUSER_W-1:0] m_tuser;

  rssi_window_signal_noise_stats_unit dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  // Predictor state
  logic signed [7:0] win_buf [DEPTH];
  int win_wr = 0;
  int win_fill = 0;
  logic signed [7:0] trk_min = MIN_START;
  logic signed [7:0] trk_max = MAX_START;

  stats_t stats_expected [$];
  int failures = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic signed [7:0] last_sample = '0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void mean_over(input div_sel_t sel, input int mid,
                                    output logic signed [7:0] mean, output logic ok);
    int sum;
    int num;
    int s;
    sum = 0;
    num = 0;
    for (int i = 0; i < win_fill; i++) begin
      s = int'(win_buf[i]);
      if (sel == DIV_ALL || (sel == DIV_SIG && s > mid) || (sel == DIV_NOISE && s <= mid)) begin
        sum += s;
        num++;
      end
    end
    ok = (num != 0);
    mean = (num == 0) ? 8'sd0 : 8'(sum / num);
  endfunction

  function automatic stats_t predict_stats(input logic op, input logic signed [7:0] smp);
    stats_t r;
    int mid;
    if (op == OP_CLEAR) begin
      win_wr = 0;
      win_fill = 0;
      trk_max = MAX_START;
      trk_min = MIN_START;
    end else begin
      if (smp > trk_max) trk_max = smp;
      if (smp < trk_min) trk_min = smp;
      win_buf[win_wr] = smp;
      win_wr = (win_wr + 1) % DEPTH;
      if (win_fill < DEPTH) win_fill++;
    end
    // midpoint truncates toward zero
    mid = (int'(trk_min) + int'(trk_max)) / 2;
    r.count = OUT_COUNT_W'(win_fill);
    r.min_v = trk_min;
    r.max_v = trk_max;
    mean_over(DIV_ALL, mid, r.all_mean, r.all_ok);
    mean_over(DIV_SIG, mid, r.sig_mean, r.sig_ok);
    mean_over(DIV_NOISE, mid, r.noise_mean, r.noise_ok);
    return r;
  endfunction

  task automatic send_item(input logic op, input logic signed [7:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'($urandom);
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= smp;
    s_tuser <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    stats_expected.push_back(predict_stats(op, smp));
  endtask

  function automatic void compare_field(input string fname, input logic [7:0] want,
                                        input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d",
               $time, fname, $signed(want), $signed(got));
      failures++;
    end
  endfunction

  // Receiver backpressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    stats_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (stats_expected.size() == 0) begin
        $display("%0t: result transfer with nothing expected: tdata %h tuser %b",
                 $time, m_tdata, m_tuser);
        failures++;
      end else begin
        want = stats_expected.pop_front();
        compare_field("sample_count", 8'(want.count), 8'(m_tdata[5:0]));
        compare_field("running_min", want.min_v, m_tdata[13:6]);
        compare_field("running_max", want.max_v, m_tdata[21:14]);
        compare_field("window_mean", want.all_mean, m_tdata[29:22]);
        compare_field("signal_mean", want.sig_mean, m_tdata[37:30]);
        compare_field("noise_mean", want.noise_mean, m_tdata[45:38]);
        compare_field("tdata_pad", 8'd0, 8'(m_tdata[47:46]));
        compare_field("mean_valid", 8'(want.all_ok), 8'(m_tuser[0]));
        compare_field("signal_valid", 8'(want.sig_ok), 8'(m_tuser[1]));
        compare_field("noise_valid", 8'(want.noise_ok), 8'(m_tuser[2]));
      end
    end
  end

  // Full-scale and bit-pattern samples; a first large positive sample leaves
  // only signal samples since the minimum still sits at zero.
  task automatic test_extremes();
    send_item(OP_ADD, 8'sd127);
    send_item(OP_ADD, -8'sd128);
    send_item(OP_ADD, 8'sd0);
    send_item(OP_ADD, -8'sd1);
    send_item(OP_ADD, -8'sd120);
    send_item(OP_ADD, -8'sd121);
    send_item(OP_ADD, 8'sd1);
    send_item(OP_ADD, 8'sh55);
    send_item(OP_ADD, 8'shAA);
    send_item(OP_ADD, 8'sd64);
  endtask

  // Clear on partly filled and empty windows; sample field must be ignored on clear.
  task automatic test_clear();
    send_item(OP_CLEAR, 8'sh7F);
    send_item(OP_CLEAR, -8'sd128);
    send_item(OP_ADD, -8'sd120);
    send_item(OP_ADD, -8'sd120);
    send_item(OP_CLEAR, 8'sd0);
    send_item(OP_ADD, 8'sd50);
    send_item(OP_ADD, 8'sd20);
  endtask

  // Equal samples sit on the midpoint: no signal set.
  task automatic test_flat_window();
    send_item(OP_CLEAR, 8'sd3);
    repeat (5) send_item(OP_ADD, -8'sd60);
    send_item(OP_ADD, -8'sd59);
    send_item(OP_ADD, -8'sd61);
  endtask

  task automatic test_random_stream(input int n, input int idle_pct, input int stall_pct);
    logic signed [7:0] smp;
    int pick;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      case ($urandom_range(9))
        0, 1, 2, 3, 4: smp = 8'(int'($urandom_range(70)) - 100);
        5, 6, 7: smp = 8'($urandom);
        8: begin
          case ($urandom_range(3))
            0: smp = -8'sd128;
            1: smp = 8'sd127;
            2: smp = -8'sd120;
            default: smp = 8'sd0;
          endcase
        end
        default: smp = last_sample;
      endcase
      if (pick < 2) begin
        send_item(OP_CLEAR, 8'($urandom));
      end else begin
        send_item(OP_ADD, smp);
        last_sample = smp;
      end
    end
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (stats_expected.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_clear();
    test_flat_window();
    test_random_stream(205, 0, 0);
    test_random_stream(205, 67, 0);
    test_random_stream(205, 0, 67);
    test_random_stream(210, 6, 6);
    wait_drain();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rwsn_pkg.sv
hdl/rwsn_ram.sv
hdl/rwsn_div.sv
hdl/rwsn_datapath.sv
hdl/rwsn_ctrl.sv
hdl/rssi_window_signal_noise_stats_unit.sv
dv/tb_rssi_window_signal_noise_stats_unit.sv
